@@ rtl/b64d_pkg.sv @@
`default_nettype none

package b64d_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_PAD   = 8'h3d;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

   localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
   localparam logic [5:0] SEXTET_PLUS       = 6'd62;
   localparam logic [5:0] SEXTET_SLASH      = 6'd63;

   // One queued job: up to three results produced by a single input character.
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] last_idx;   // number of results minus one
      logic       has_bytes;
      logic       stream_last;
      logic       length_error;
   } job_type;

   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [5:0] v;
      v = 6'd0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         v = 6'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         v = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         v = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
      end else if (c == CHAR_PLUS) begin
         v = SEXTET_PLUS;
      end else if (c == CHAR_SLASH) begin
         v = SEXTET_SLASH;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

@@ rtl/b64d_front.sv @@
`default_nettype none

module b64d_front
   import b64d_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_char
   input  wire logic       req_tlast,   // in_last
   input  wire logic       queue_full,
   output logic            push,
   output job_type         push_job
);

   logic [17:0] acc_ff, acc_in;
   logic [1:0]  pos_ff, pos_in;
   logic [1:0]  len_ff, len_in;
   logic        pad3_ff, pad3_in;

   logic        accept;
   logic        is_crlf;
   logic        is_pad;
   logic        completes;
   logic [5:0]  v;
   logic [7:0]  b0, b1, b2;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign is_crlf    = (req_tdata == CHAR_CR) || (req_tdata == CHAR_LF);
   assign is_pad     = req_tdata == CHAR_PAD;
   assign v          = sextet_of(req_tdata);
   assign completes  = !is_crlf && (pos_ff == 2'd3);

   assign b0 = {acc_ff[17:12], acc_ff[11:10]};
   assign b1 = {acc_ff[9:6], acc_ff[5:2]};
   assign b2 = {acc_ff[1:0], v};

   always_comb begin
      len_in  = len_ff + 2'd1;
      acc_in  = acc_ff;
      pos_in  = pos_ff;
      pad3_in = pad3_ff;

      push_job              = '0;
      push_job.stream_last  = req_tlast;
      push_job.length_error = len_in != 2'd0;

      if (completes) begin
         push_job.has_bytes = 1'b1;
         push_job.byte0     = b0;
         push_job.byte1     = pad3_ff ? b2 : b1;
         push_job.byte2     = b2;
         push_job.last_idx  = 2'(!pad3_ff) + 2'(!is_pad);
         acc_in  = '0;
         pos_in  = 2'd0;
         pad3_in = 1'b0;
      end else if (!is_crlf) begin
         if (pos_ff == 2'd2) begin
            pad3_in = is_pad;
         end
         acc_in = {acc_ff[11:0], v};
         pos_in = pos_ff + 2'd1;
      end

      if (req_tlast) begin
         acc_in  = '0;
         pos_in  = 2'd0;
         len_in  = 2'd0;
         pad3_in = 1'b0;
      end

      push = accept && (completes || req_tlast);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pos_ff  <= '0;
         len_ff  <= '0;
         pad3_ff <= 1'b0;
      end else if (accept) begin
         acc_ff  <= acc_in;
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         pad3_ff <= pad3_in;
      end
   end

   a_empty_job_is_final: assert property (@(posedge clock) disable iff (reset)
      push && !push_job.has_bytes |-> push_job.stream_last && push_job.last_idx == 2'd0)
      else $error("job without bytes is not a lone final result");

endmodule

`default_nettype wire

@@ rtl/b64d_queue.sv @@
`default_nettype none

module b64d_queue
   import b64d_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      head,
   output logic         empty
);

   job_type                  slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ff, rd_ff;
   logic [QUEUE_PTR_W:0]     count_ff;

   assign full  = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = slots_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + QUEUE_PTR_W'(1);
         end
         count_ff <= count_ff + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ rtl/b64d_back.sv @@
`default_nettype none

module b64d_back
   import b64d_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire job_type    head,
   input  wire logic       empty,
   output logic            pop,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic [2:0]      rsp_tuser,   // [0] byte_valid, [1] group_end, [2] length_error
   output logic            rsp_tlast    // stream_end
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff;
   logic [7:0] byte_ff, byte_in;
   logic [2:0] user_ff, user_in;
   logic       last_ff, last_in;
   logic       load;
   logic       fin;

   assign load = !empty && (!valid_ff || rsp_tready);
   assign fin  = idx_ff == head.last_idx;
   assign pop  = load && fin;

   always_comb begin
      unique case (idx_ff)
         2'd0:    byte_in = head.byte0;
         2'd1:    byte_in = head.byte1;
         default: byte_in = head.byte2;
      endcase
      user_in = {fin && head.stream_last && head.length_error, fin, head.has_bytes};
      last_in = fin && head.stream_last;
      idx_in  = fin ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= idx_in;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         user_ff <= user_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> idx_ff <= head.last_idx)
      else $error("result index beyond job");

   a_idx_zero_idle: assert property (@(posedge clock) disable iff (reset)
      empty |-> idx_ff == 2'd0)
      else $error("result index not cleared between jobs");

endmodule

`default_nettype wire

@@ rtl/base64_stream_decoder.sv @@
`default_nettype none

// Channel  Direction  tdata            tuser                                    tlast
// req      in         [7:0] in_char    -                                        in_last
// rsp      out        [7:0] out_byte   [0] byte_valid [1] group_end [2] length_error  stream_end
//
// One character is taken per cycle while the job queue has room. Each
// result passes through the job queue and the output register, and the
// back end sends one result per cycle while rsp_tready is high. A character
// that completes a group yields up to three results (three per four characters).
// Synchronous reset clears group state, the job queue and the output valid flag.
// req_tready drops only while the four-entry job queue is full.

module base64_stream_decoder
   import b64d_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_char
   input  wire logic       req_tlast,   // in_last
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic [2:0]      rsp_tuser,   // [0] byte_valid, [1] group_end, [2] length_error
   output logic            rsp_tlast    // stream_end
);

   job_type push_job;
   job_type head;
   logic    push;
   logic    pop;
   logic    full;
   logic    empty;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (full),
      .push       (push),
      .push_job   (push_job)
   );

   b64d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
